[hw/rtl/tcc_pkg.sv]
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int MAX_PATTERN_W = 16;
	localparam int MAX_PATTERN_H = 16;
	localparam int MAX_IMAGE_W = 1024;
	localparam int IMAGE_H_MAX = 4096;

	localparam int PW_W = $clog2(MAX_PATTERN_W + 1);
	localparam int PH_W = $clog2(MAX_PATTERN_H + 1);
	localparam int TPL_DEPTH = MAX_PATTERN_W * MAX_PATTERN_H;
	localparam int TPL_AW = $clog2(TPL_DEPTH);
	localparam int ROW_AW = $clog2(MAX_PATTERN_H);
	localparam int COL_W = $clog2(MAX_IMAGE_W);
	localparam int IW_W = $clog2(MAX_IMAGE_W + 1);
	localparam int IH_W = 13;
	localparam int ROW_W = 12;
	localparam int SCORE_W = 24;
	localparam int POSX_W = 10;
	localparam int POSY_W = 12;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_W = 2'd0,
		REG_PATTERN_H = 2'd1,
		REG_IMAGE_W   = 2'd2,
		REG_IMAGE_H   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ACT_TEMPLATE = 1'b0,
		ACT_IMAGE    = 1'b1
	} action_t;

	typedef struct packed {
		logic              tpl_we;
		logic [TPL_AW-1:0] tpl_addr;
		logic              line_we;
		logic [ROW_AW-1:0] line_row;
		logic [COL_W-1:0]  line_col;
		logic [7:0]        pixel;
	} mem_wr_t;

	typedef struct packed {
		logic [COL_W-1:0]  x;
		logic [ROW_AW-1:0] row;
		logic [ROW_W-1:0]  y;
		logic              last;
	} job_t;

	typedef struct packed {
		logic [PW_W-1:0] pw;
		logic [PH_W-1:0] ph;
	} shape_t;

	typedef struct packed {
		logic busy;
		logic start;
	} back_status_t;

endpackage

[hw/rtl/template_cross_correlation.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// config    in         cfg_we               cfg_index, cfg_data
// input     in         in_valid, in_stall   action, pixel
// result    out        out_valid, out_stall score, pos_x, pos_y, last
//
// A template load, or an image pixel with no full placement, causes no stall.
// An image pixel with a placement stalls the input while the single
// multiply-accumulate unit walks the window.
// Reset clears counters, loads default sizes; pixel memories hold garbage until written.
// The input stalls while a window is queued or being summed; a held result keeps
// the next window queued, so the input stays stalled until that result transfers.

module template_cross_correlation import tcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [7:0]            pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SCORE_W-1:0]    score,
	output logic [POSX_W-1:0]     pos_x,
	output logic [POSY_W-1:0]     pos_y,
	output logic                  last
);

	mem_wr_t      wr;
	shape_t       shape;
	job_t         job, head;
	logic         job_push, job_pop, q_nonempty;
	logic [1:0]   q_count;
	back_status_t status;

	assign in_stall = q_nonempty || status.busy;

	tcc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .hold(in_stall), .action(action), .pixel(pixel),
		.wr(wr), .job_push(job_push), .job(job), .shape(shape)
	);

	tcc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(job_push), .push_job(job), .pop(job_pop),
		.nonempty(q_nonempty), .count(q_count), .head(head)
	);

	tcc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.wr(wr), .shape(shape),
		.job_avail(q_nonempty), .job_in(head), .job_pop(job_pop), .status(status),
		.out_valid(out_valid), .out_stall(out_stall),
		.score(score), .pos_x(pos_x), .pos_y(pos_y), .last(last)
	);

	a_queue_shallow: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 2'd1) else $error("job queue holds more than one window");

	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !status.busy && !q_nonempty)
		else $error("window queued while another is pending");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(status.busy))
		else $error("result appeared without a window being summed");

	a_start_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		status.start |-> !out_valid) else $error("window started over a held result");

endmodule

[hw/rtl/tcc_front.sv]
`timescale 1ns / 1ps

module tcc_front import tcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  hold,
	input  logic                  action,
	input  logic [7:0]            pixel,
	output mem_wr_t               wr,
	output logic                  job_push,
	output job_t                  job,
	output shape_t                shape
);

	logic [4:0]        pw_cfg_q, ph_cfg_q;
	logic [10:0]       iw_cfg_q;
	logic [12:0]       ih_cfg_q;
	logic [PW_W-1:0]   pw_c;
	logic [PH_W-1:0]   ph_c;
	logic [IW_W-1:0]   iw_c;
	logic [IH_W-1:0]   ih_c;
	logic [TPL_AW:0]   area;
	logic [TPL_AW:0]   tcnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_AW-1:0] rmod_q;
	logic              accept, is_img, hit, col_end, row_end;
	logic [ROW_AW:0]   yrow;

	assign pw_c = (pw_cfg_q == 5'd0) ? PW_W'(1) :
		(32'(pw_cfg_q) > MAX_PATTERN_W) ? PW_W'(MAX_PATTERN_W) : PW_W'(pw_cfg_q);
	assign ph_c = (ph_cfg_q == 5'd0) ? PH_W'(1) :
		(32'(ph_cfg_q) > MAX_PATTERN_H) ? PH_W'(MAX_PATTERN_H) : PH_W'(ph_cfg_q);
	assign iw_c = (iw_cfg_q == 11'd0) ? IW_W'(1) :
		(32'(iw_cfg_q) > MAX_IMAGE_W) ? IW_W'(MAX_IMAGE_W) : IW_W'(iw_cfg_q);
	assign ih_c = (ih_cfg_q == 13'd0) ? IH_W'(1) :
		(32'(ih_cfg_q) > IMAGE_H_MAX) ? IH_W'(IMAGE_H_MAX) : IH_W'(ih_cfg_q);
	assign area = (TPL_AW+1)'(32'(pw_c) * 32'(ph_c));

	assign shape.pw = pw_c;
	assign shape.ph = ph_c;

	assign accept = in_valid && !hold;
	assign is_img = (action == ACT_IMAGE);

	assign hit = (32'(pw_c) <= 32'(iw_c)) && (32'(ph_c) <= 32'(ih_c)) &&
		(32'(col_q) + 32'd1 >= 32'(pw_c)) && (32'(row_q) + 32'd1 >= 32'(ph_c));
	assign col_end = (32'(col_q) + 32'd1 == 32'(iw_c));
	assign row_end = (32'(row_q) + 32'd1 == 32'(ih_c));

	always_comb begin
		yrow = (ROW_AW+1)'(32'(rmod_q) + MAX_PATTERN_H - (32'(ph_c) - 32'd1));
		if (32'(yrow) >= MAX_PATTERN_H) begin
			yrow = (ROW_AW+1)'(32'(yrow) - MAX_PATTERN_H);
		end
	end

	assign wr.tpl_we = accept && !is_img;
	assign wr.tpl_addr = tcnt_q[TPL_AW-1:0];
	assign wr.line_we = accept && is_img;
	assign wr.line_row = rmod_q;
	assign wr.line_col = col_q;
	assign wr.pixel = pixel;

	assign job_push = accept && is_img && hit;
	assign job.x = COL_W'(32'(col_q) + 32'd1 - 32'(pw_c));
	assign job.row = yrow[ROW_AW-1:0];
	assign job.y = ROW_W'(32'(row_q) + 32'd1 - 32'(ph_c));
	assign job.last = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_cfg_q <= 5'd16;
			ph_cfg_q <= 5'd16;
			iw_cfg_q <= 11'd1024;
			ih_cfg_q <= 13'd1024;
			tcnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			rmod_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_PATTERN_W: pw_cfg_q <= cfg_data[4:0];
				REG_PATTERN_H: ph_cfg_q <= cfg_data[4:0];
				REG_IMAGE_W:   iw_cfg_q <= cfg_data[10:0];
				REG_IMAGE_H:   ih_cfg_q <= cfg_data[12:0];
				default:       ih_cfg_q <= ih_cfg_q;
			endcase
			tcnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			rmod_q <= '0;
		end else if (accept) begin
			if (!is_img) begin
				if (tcnt_q + 1'b1 >= area) begin
					tcnt_q <= '0;
				end else begin
					tcnt_q <= tcnt_q + 1'b1;
				end
			end else if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
					rmod_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (32'(rmod_q) == MAX_PATTERN_H - 1) begin
						rmod_q <= '0;
					end else begin
						rmod_q <= rmod_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[hw/rtl/tcc_queue.sv]
`timescale 1ns / 1ps

module tcc_queue import tcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output logic       nonempty,
	output logic [1:0] count,
	output job_t       head
);

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign do_push = push && (count_q != 2'd2);
	assign do_pop = pop && (count_q != 2'd0);
	assign nonempty = (count_q != 2'd0);
	assign count = count_q;
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/tcc_back.sv]
`timescale 1ns / 1ps

module tcc_back import tcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mem_wr_t            wr,
	input  shape_t             shape,
	input  logic               job_avail,
	input  job_t               job_in,
	output logic               job_pop,
	output back_status_t       status,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SCORE_W-1:0] score,
	output logic [POSX_W-1:0]  pos_x,
	output logic [POSY_W-1:0]  pos_y,
	output logic               last
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	logic [7:0] tpl_mem [TPL_DEPTH];
	logic [7:0] line_mem [MAX_PATTERN_H][MAX_IMAGE_W];

	state_t             state_q;
	job_t               job_q;
	logic [PW_W-1:0]    i_q;
	logic [PH_W-1:0]    j_q;
	logic [TPL_AW-1:0]  ta_q;
	logic [ROW_AW-1:0]  rp_q;
	logic [COL_W-1:0]   cx_q;
	logic               start, issue, issue_last, i_end;
	logic               v_s1, last_s1, v_s2, last_s2;
	logic [7:0]         t_s1, l_s1;
	logic [15:0]        prod_s2;
	logic [SCORE_W-1:0] acc_q;
	logic [SCORE_W-1:0] acc_next;
	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;
	logic [POSX_W-1:0]  pos_x_q;
	logic [POSY_W-1:0]  pos_y_q;
	logic               last_q;

	assign start = (state_q == ST_IDLE) && job_avail && !out_valid_q;
	assign job_pop = start;
	assign issue = (state_q == ST_RUN);
	assign i_end = (32'(i_q) + 32'd1 == 32'(shape.pw));
	assign issue_last = i_end && (32'(j_q) + 32'd1 == 32'(shape.ph));
	assign acc_next = acc_q + SCORE_W'(prod_s2);

	assign status.busy = (state_q != ST_IDLE);
	assign status.start = start;

	always_ff @(posedge clk) begin
		if (wr.tpl_we) begin
			tpl_mem[wr.tpl_addr] <= wr.pixel;
		end
		if (wr.line_we) begin
			line_mem[wr.line_row][wr.line_col] <= wr.pixel;
		end
		t_s1 <= tpl_mem[ta_q];
		l_s1 <= line_mem[rp_q][cx_q];
		prod_s2 <= 16'(t_s1) * 16'(l_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ta_q <= '0;
			rp_q <= '0;
			cx_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			score_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			last_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			last_s1 <= issue && issue_last;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						job_q <= job_in;
						i_q <= '0;
						j_q <= '0;
						ta_q <= '0;
						rp_q <= job_in.row;
						cx_q <= job_in.x;
						acc_q <= '0;
					end
				end
				ST_RUN: begin
					ta_q <= ta_q + 1'b1;
					if (i_end) begin
						i_q <= '0;
						j_q <= j_q + 1'b1;
						cx_q <= job_q.x;
						if (32'(rp_q) == MAX_PATTERN_H - 1) begin
							rp_q <= '0;
						end else begin
							rp_q <= rp_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
						cx_q <= cx_q + 1'b1;
					end
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (last_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s2) begin
				acc_q <= acc_next;
			end
			if (last_s2) begin
				out_valid_q <= 1'b1;
				score_q <= acc_next;
				pos_x_q <= POSX_W'(job_q.x);
				pos_y_q <= job_q.y;
				last_q <= job_q.last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign score = score_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign last = last_q;

endmodule

[tb/sv/template_cross_correlation_checker.sv]
`timescale 1ns / 1ps

module template_cross_correlation_checker import tcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  action,
	input  logic [7:0]            pixel,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [SCORE_W-1:0]    score,
	input  logic [POSX_W-1:0]     pos_x,
	input  logic [POSY_W-1:0]     pos_y,
	input  logic                  last,
	output int                    pending,
	output int                    errors
);

	typedef struct {
		logic [SCORE_W-1:0] score;
		logic [POSX_W-1:0]  x;
		logic [POSY_W-1:0]  y;
		logic               last;
	} placement_t;

	placement_t placements_q[$];

	logic [7:0] tpl_pixels [TPL_DEPTH];
	logic [7:0] recent_rows [MAX_PATTERN_H][MAX_IMAGE_W];
	int unsigned tpl_cnt, col_cnt, row_cnt;
	logic [4:0] pw_reg, ph_reg;
	logic [10:0] iw_reg;
	logic [12:0] ih_reg;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Advances the shadow state by one pixel and queues the placement it completes.
	task automatic predict_pixel(logic act, logic [7:0] px);
		int unsigned pw, ph, iw, ih, c, r, x, y;
		logic [31:0] acc;
		placement_t p;
		pw = clamp_dim(pw_reg, MAX_PATTERN_W);
		ph = clamp_dim(ph_reg, MAX_PATTERN_H);
		iw = clamp_dim(iw_reg, MAX_IMAGE_W);
		ih = clamp_dim(ih_reg, IMAGE_H_MAX);
		if (action_t'(act) == ACT_TEMPLATE) begin
			if (tpl_cnt >= pw * ph) tpl_cnt = 0;
			tpl_pixels[tpl_cnt % TPL_DEPTH] = px;
			tpl_cnt++;
			if (tpl_cnt >= pw * ph) tpl_cnt = 0;
			return;
		end
		if (col_cnt >= iw) col_cnt = 0;
		if (row_cnt >= ih) row_cnt = 0;
		c = col_cnt;
		r = row_cnt;
		recent_rows[r % MAX_PATTERN_H][c % MAX_IMAGE_W] = px;
		if (pw <= iw && ph <= ih && c + 1 >= pw && r + 1 >= ph) begin
			x = c + 1 - pw;
			y = r + 1 - ph;
			acc = 0;
			for (int j = 0; j < ph; j++)
				for (int i = 0; i < pw; i++)
					acc += tpl_pixels[(j * pw + i) % TPL_DEPTH] *
						recent_rows[(y + j) % MAX_PATTERN_H][(x + i) % MAX_IMAGE_W];
			p.score = acc[SCORE_W-1:0];
			p.x = x[POSX_W-1:0];
			p.y = y[POSY_W-1:0];
			p.last = (c + 1 == iw && r + 1 == ih);
			placements_q.push_back(p);
		end
		col_cnt = c + 1;
		if (col_cnt >= iw) begin
			col_cnt = 0;
			row_cnt = r + 1;
			if (row_cnt >= ih) row_cnt = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			placements_q.delete();
			tpl_cnt = 0;
			col_cnt = 0;
			row_cnt = 0;
			pw_reg = 16;
			ph_reg = 16;
			iw_reg = 1024;
			ih_reg = 1024;
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (placements_q.size() == 0) begin
					$display("%0t: unexpected result score=%0d x=%0d y=%0d last=%0d",
						$time, score, pos_x, pos_y, last);
					errors++;
				end else begin
					want = placements_q.pop_front();
					if (score !== want.score || pos_x !== want.x || pos_y !== want.y ||
							last !== want.last) begin
						$display("%0t: expected score=%0d x=%0d y=%0d last=%0d, got score=%0d x=%0d y=%0d last=%0d",
							$time, want.score, want.x, want.y, want.last,
							score, pos_x, pos_y, last);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					REG_PATTERN_W: pw_reg = cfg_data[4:0];
					REG_PATTERN_H: ph_reg = cfg_data[4:0];
					REG_IMAGE_W:   iw_reg = cfg_data[10:0];
					REG_IMAGE_H:   ih_reg = cfg_data[12:0];
					default:       ;
				endcase
				tpl_cnt = 0;
				col_cnt = 0;
				row_cnt = 0;
			end
			if (in_valid && !in_stall)
				predict_pixel(action, pixel);
			pending = placements_q.size();
		end
	end

endmodule

[tb/sv/template_cross_correlation_tb.sv]
`timescale 1ns / 1ps

module template_cross_correlation_tb;
	import tcc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [7:0]            pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [SCORE_W-1:0]    score;
	logic [POSX_W-1:0]     pos_x;
	logic [POSY_W-1:0]     pos_y;
	logic                  last;
	int                    pending;
	int                    errors;

	int  send_idle_pct;
	int  recv_idle_pct;
	logic hold_req;
	int  items_sent;

	template_cross_correlation u_dut (.*);

	template_cross_correlation_checker u_checker (.*);

	always #4 clk = ~clk;

	initial begin
		#(8 * 3000000);
		$display("template_cross_correlation_tb NOT OK");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		bit held;
		out_stall = 1'b0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (2000) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Called at a rising edge; returns at the edge where the transfer happens.
	task automatic send_pixel(action_t a, logic [7:0] px);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		pixel <= px;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(v);
		@(posedge clk);
	endtask

	// One setting: write all registers, load a full template, stream pixels, then drain.
	task automatic run_setting(int unsigned pw_raw, int unsigned ph_raw, int unsigned iw_raw,
			int unsigned ih_raw, int n_pix, bit saturate, bit mixed);
		int unsigned pw, ph;
		pw = clamp_dim(pw_raw & 5'h1f, MAX_PATTERN_W);
		ph = clamp_dim(ph_raw & 5'h1f, MAX_PATTERN_H);
		write_reg(REG_PATTERN_W, pw_raw);
		write_reg(REG_PATTERN_H, ph_raw);
		write_reg(REG_IMAGE_W, iw_raw);
		write_reg(REG_IMAGE_H, ih_raw);
		cfg_we <= 1'b0;
		for (int k = 0; k < pw * ph; k++)
			send_pixel(ACT_TEMPLATE, saturate ? 8'd255 : rand_pixel());
		for (int k = 0; k < n_pix; k++) begin
			if (mixed && $urandom_range(19) == 0)
				send_pixel(ACT_TEMPLATE, rand_pixel());
			send_pixel(ACT_IMAGE, saturate ? 8'd255 : rand_pixel());
		end
		drain();
	endtask

	task automatic set_idle_mode(int m);
		case (m % 4)
			0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1: begin send_idle_pct = 68; recv_idle_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_idle_pct = 68; end
			default: begin send_idle_pct = 38; recv_idle_pct = 38; end
		endcase
	endtask

	initial begin
		int unsigned pw, ph, iw, ih;
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PATTERN_W;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_TEMPLATE;
		pixel = 8'd0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero sizes count as one; an over-range width clamps to the maximum.
		run_setting(0, 0, 2047, 1, 20, 0, 0);
		set_idle_mode(3);
		run_setting(1, 1, 1, 8191, 20, 0, 0);
		set_idle_mode(0);
		// Over-range template sizes clamp to the maximum; saturated pixels.
		run_setting(1, 31, 1, 16, 16, 1, 0);
		set_idle_mode(2);
		run_setting(31, 1, 16, 1, 16, 1, 0);
		// Templates wider or taller than the image give nothing.
		run_setting(4, 2, 3, 5, 15, 0, 0);
		run_setting(2, 5, 6, 3, 18, 0, 0);

		// The result side holds off while pixels are offered, so the input stalls behind the held result.
		set_idle_mode(0);
		hold_req <= 1'b1;
		@(posedge clk);
		run_setting(2, 2, 8, 8, 64, 0, 1);

		phase = 0;
		while (items_sent < 400) begin
			set_idle_mode(phase++);
			pw = $urandom_range(1, 4);
			ph = $urandom_range(1, 4);
			iw = $urandom_range(pw, 8);
			ih = $urandom_range(ph, 8);
			if ($urandom_range(9) == 0) iw = $urandom_range(1, 8);
			run_setting(pw, ph, iw, ih, $urandom_range(1, 2 * iw * ih), 0, 1);
		end

		if (errors == 0)
			$display("template_cross_correlation_tb OK");
		else
			$display("template_cross_correlation_tb NOT OK");
		$finish;
	end

endmodule
